[rtl/positional_ordered_list_unit_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef POSITIONAL_ORDERED_LIST_UNIT_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define POLU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define POLU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/polu_pkg.sv]
package polu_pkg;

  localparam int CAPACITY_DEF = 16;

  // Request codes.
  localparam logic [2:0] OP_ADD_FRONT = 3'd0;
  localparam logic [2:0] OP_ADD_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT_AT = 3'd2;
  localparam logic [2:0] OP_REM_FRONT = 3'd3;
  localparam logic [2:0] OP_REM_BACK  = 3'd4;
  localparam logic [2:0] OP_REM_AT    = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [4:0]         position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [4:0]         count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the request
    logic init;      // load the entry index
    logic rd_here;   // read the entry at the index
    logic grab;      // keep the read data as the removed value
    logic wr_shift;  // move one entry and step the index
    logic put;       // write the new value at the index
    logic finish;    // update the count and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;         // request fails or does nothing
    logic ins;          // successful insert
    logic ins_shift;    // insert has entries to move up
    logic rem_more;     // removal has entries to move down from the index
    logic last;         // the current move is the final one
    logic out_blocked;  // result register holds an untaken result
  } sts_t;

endpackage

[rtl/polu_ram.sv]
module polu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/polu_ctrl.sv]
module polu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  polu_pkg::sts_t sts,
  output polu_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_WR,
    S_PUT,
    S_TAKE_RD,
    S_TAKE,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.init = 1'b1;
        if (sts.skip) begin
          state_nxt = S_DONE;
        end else if (sts.ins) begin
          state_nxt = sts.ins_shift ? S_RD : S_PUT;
        end else begin
          state_nxt = S_TAKE_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr_shift = 1'b1;
        if (sts.last) begin
          state_nxt = sts.ins ? S_PUT : S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_DONE;
      end
      S_TAKE_RD: begin
        cmd.rd_here = 1'b1;
        state_nxt   = S_TAKE;
      end
      S_TAKE: begin
        cmd.grab  = 1'b1;
        state_nxt = sts.rem_more ? S_RD : S_DONE;
      end
      S_DONE: begin
        if (!sts.out_blocked) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/polu_dp.sv]
module polu_dp #(
  parameter int CAPACITY = polu_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  polu_pkg::in_t  in_data,
  input  polu_pkg::cmd_t cmd,
  output polu_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_stall,
  output polu_pkg::out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > 5) ? CW : 5;

  polu_pkg::in_t      req_r;
  logic [CW-1:0]      occ_r;
  logic [CW-1:0]      occ_nxt;
  logic [AW-1:0]      idx_r;
  logic signed [31:0] removed_r;
  logic               out_valid_r;
  polu_pkg::out_t     out_data_r;

  logic [MW-1:0] pos_m;
  logic [MW-1:0] occ_m;
  logic [CW-1:0] occ_dec;
  logic          full;
  logic          empty;
  logic [1:0]    status;
  logic          ins_ok;
  logic          rem_ok;
  logic [AW-1:0] at;
  logic [CW:0]   idx_w;
  logic [CW:0]   occ_w;

  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic          we;
  logic [31:0]   wdata;

  assign pos_m   = MW'(req_r.position);
  assign occ_m   = MW'(occ_r);
  assign occ_dec = occ_r - CW'(1);
  assign full    = (occ_r == CW'(CAPACITY));
  assign empty   = (occ_r == '0);

  // Outcome of the held request against the current count.
  always_comb begin
    status = polu_pkg::ST_OK;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    at     = '0;
    case (req_r.op)
      polu_pkg::OP_ADD_FRONT: begin
        if (full) status = polu_pkg::ST_FULL;
        else ins_ok = 1'b1;
      end
      polu_pkg::OP_ADD_BACK: begin
        if (full) status = polu_pkg::ST_FULL;
        else ins_ok = 1'b1;
        at = occ_r[AW-1:0];
      end
      polu_pkg::OP_INSERT_AT: begin
        if (pos_m > occ_m) status = polu_pkg::ST_BADPOS;
        else if (full) status = polu_pkg::ST_FULL;
        else ins_ok = 1'b1;
        at = pos_m[AW-1:0];
      end
      polu_pkg::OP_REM_FRONT: begin
        if (empty) status = polu_pkg::ST_EMPTY;
        else rem_ok = 1'b1;
      end
      polu_pkg::OP_REM_BACK: begin
        if (empty) status = polu_pkg::ST_EMPTY;
        else rem_ok = 1'b1;
        at = occ_dec[AW-1:0];
      end
      polu_pkg::OP_REM_AT: begin
        if (pos_m >= occ_m) status = polu_pkg::ST_BADPOS;
        else rem_ok = 1'b1;
        at = pos_m[AW-1:0];
      end
      default: begin
        status = polu_pkg::ST_OK;
      end
    endcase
  end

  assign idx_w = (CW + 1)'(idx_r);
  assign occ_w = {1'b0, occ_r};

  // Inserts walk the index down toward the slot; removals walk it up to the back.
  assign sts.skip        = !(ins_ok || rem_ok);
  assign sts.ins         = ins_ok;
  assign sts.ins_shift   = (occ_r != CW'(at));
  assign sts.rem_more    = ((idx_w + (CW + 1)'(1)) < occ_w);
  assign sts.last        = ins_ok ? ((idx_r - AW'(1)) == at)
                                  : ((idx_w + (CW + 1)'(2)) >= occ_w);
  assign sts.out_blocked = out_valid_r && out_stall;

  always_comb begin
    if (cmd.rd_here) begin
      raddr = idx_r;
    end else if (ins_ok) begin
      raddr = idx_r - AW'(1);
    end else begin
      raddr = idx_r + AW'(1);
    end
  end

  assign we    = cmd.wr_shift || cmd.put;
  assign wdata = cmd.put ? req_r.value : rdata;

  polu_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    occ_nxt = occ_r;
    if (ins_ok) begin
      occ_nxt = occ_r + CW'(1);
    end else if (rem_ok) begin
      occ_nxt = occ_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r     <= in_data;
      removed_r <= '0;
    end
    if (cmd.grab) begin
      removed_r <= rdata;
    end
    if (cmd.init) begin
      idx_r <= ins_ok ? occ_r[AW-1:0] : at;
    end else if (cmd.wr_shift) begin
      idx_r <= ins_ok ? (idx_r - AW'(1)) : (idx_r + AW'(1));
    end
    if (cmd.finish) begin
      out_data_r.removed_value <= removed_r;
      out_data_r.status        <= status;
      out_data_r.count         <= 5'(occ_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/positional_ordered_list_unit.sv]
// Ordered list of up to CAPACITY signed 32-bit values kept in a single-port-write,
// registered-read RAM. A request adds or removes at the front, the back or a
// given position, and one result per request reports the removed value (zero
// unless a removal succeeds), a status and the new count. Failed requests leave
// the list unchanged. Requests are handled one at a time and the input stalls
// while one is in progress. Each entry moved goes through the RAM as a read, then
// a write back one place over; a removal also reads the element first. The result
// register lets the next request be taken while a result still waits on out_stall.
module positional_ordered_list_unit #(
  parameter int CAPACITY = polu_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  polu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output polu_pkg::out_t out_data
);

  polu_pkg::cmd_t cmd;
  polu_pkg::sts_t sts;

  polu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  polu_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/polu_chk.sv]
`include "positional_ordered_list_unit_macros.svh"

module polu_chk #(
  parameter int CAPACITY = polu_pkg::CAPACITY_DEF
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input polu_pkg::out_t out_data
);

  // A result that is not taken stays on the port unchanged.
  `POLU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Every request passes through the controller states, so the input is busy right after a transfer.
  `POLU_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

  // Only a successful removal reports a value.
  `POLU_ASSERT_NOW(a_removed_zero, out_valid && (out_data.status != polu_pkg::ST_OK), out_data.removed_value == 32'sd0)

  // An empty report always comes with a count of zero.
  `POLU_ASSERT_NOW(a_empty_count, out_valid && (out_data.status == polu_pkg::ST_EMPTY), out_data.count == 5'd0)

  // The count never passes the capacity where the count field can show it.
  `POLU_ASSERT_NOW(a_count_cap, out_valid && (CAPACITY < 32), 32'(out_data.count) <= CAPACITY)

endmodule

bind positional_ordered_list_unit polu_chk #(.CAPACITY(CAPACITY)) u_polu_chk (.*);
